// ===== rtl/h264_parameter_set_capture_top_defines.svh =====
// Assertion macros for the parameter set capture block.
// The asserting module provides clk and arst_n.
`ifndef H264_PARAMETER_SET_CAPTURE_TOP_DEFINES_SVH
`define H264_PARAMETER_SET_CAPTURE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define H264PSC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define H264PSC_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define H264PSC_ASSERT(lbl, prop, msg)
`define H264PSC_NEVER(lbl, cond, msg)
`endif

`endif

// ===== rtl/h264psc_pkg.sv =====
package h264psc_pkg;

	localparam int NAL_TYPE_W = 5;

	localparam logic CMD_SCAN = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam logic [NAL_TYPE_W-1:0] NAL_SPS = 5'd7;
	localparam logic [NAL_TYPE_W-1:0] NAL_PPS = 5'd8;

	localparam logic [7:0] START_BYTE  = 8'h01;
	localparam logic [7:0] REC_VERSION = 8'h01;
	localparam logic [7:0] REC_LEN_SIZE = 8'hff;
	localparam logic [7:0] REC_NUM_SPS = 8'he1;
	localparam logic [7:0] REC_NUM_PPS = 8'h01;
	localparam int MIN_SET_LEN = 4;

	typedef enum logic [2:0] {
		PH_HUNT = 3'b001,
		PH_HDR  = 3'b010,
		PH_BODY = 3'b100
	} phase_t;

	typedef enum logic [2:0] {
		TGT_NONE = 3'b001,
		TGT_SEQ  = 3'b010,
		TGT_PIC  = 3'b100
	} target_t;

	typedef struct packed {
		logic [NAL_TYPE_W-1:0] nal_kind;
		logic                  in_body;
		logic                  locked;
		logic                  too_long;
	} status_t;

endpackage

// ===== rtl/h264psc_ram.sv =====
module h264psc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/h264psc_scan.sv =====
module h264psc_scan
	import h264psc_pkg::*;
#(
	parameter int NAL_MAX = 64,
	localparam int LW = $clog2(NAL_MAX + 5),
	localparam int AW = $clog2(NAL_MAX)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic [7:0]    data_byte,
	input  logic          last_of_frame,
	input  logic          key_frame,
	output logic          seq_we,
	output logic          pic_we,
	output logic [AW-1:0] waddr,
	output logic [LW-1:0] seq_len,
	output logic [LW-1:0] pic_len,
	output status_t       sts
);

	localparam int LEN_CAP = NAL_MAX + 4;

	typedef struct packed {
		logic          ovf;
		logic [LW-1:0] len;
	} close_t;

	logic [1:0]            zr_q, n_zr;
	phase_t                ph_q, n_ph;
	logic [NAL_TYPE_W-1:0] ut_q, n_ut;
	target_t               tg_q, n_tg, app_tg;
	logic [LW-1:0]         sl_q, n_sl, pl_q, n_pl;
	logic                  ov_q, n_ov, lk_q, n_lk;
	close_t                cs;

	// Trim the zeros that belong to the next start code; drop oversize sets.
	function automatic close_t close_len(input logic [LW-1:0] len, input logic [1:0] drop);
		close_t r;
		logic [LW-1:0] d;
		d = LW'(drop);
		r.ovf = 1'b0;
		r.len = (len >= d) ? len - d : '0;
		if (r.len > LW'(NAL_MAX)) begin
			r.ovf = 1'b1;
			r.len = '0;
		end
		return r;
	endfunction

	always_comb begin
		n_zr   = zr_q;
		n_ph   = ph_q;
		n_ut   = ut_q;
		n_tg   = tg_q;
		n_sl   = sl_q;
		n_pl   = pl_q;
		n_ov   = ov_q;
		n_lk   = lk_q;
		app_tg = TGT_NONE;
		cs     = '0;
		seq_we = 1'b0;
		pic_we = 1'b0;
		waddr  = '0;
		if (en && !lk_q) begin
			if (key_frame) begin
				case (ph_q)
					PH_HDR: begin
						n_ut = data_byte[NAL_TYPE_W-1:0];
						if (n_ut == NAL_SPS && sl_q == '0) begin
							n_tg = TGT_SEQ;
						end else if (n_ut == NAL_PPS && pl_q == '0) begin
							n_tg = TGT_PIC;
						end else begin
							n_tg = TGT_NONE;
						end
						app_tg = n_tg;
						n_zr   = '0;
						n_ph   = PH_BODY;
					end
					default: begin
						if (data_byte == START_BYTE && zr_q >= 2'd2) begin
							if (ph_q == PH_BODY) begin
								case (tg_q)
									TGT_SEQ: begin
										cs   = close_len(sl_q, zr_q);
										n_sl = cs.len;
										n_ov = n_ov | cs.ovf;
									end
									TGT_PIC: begin
										cs   = close_len(pl_q, zr_q);
										n_pl = cs.len;
										n_ov = n_ov | cs.ovf;
									end
									default: ;
								endcase
								if (tg_q != TGT_NONE && n_sl != '0 && n_pl != '0) begin
									n_lk = 1'b1;
								end
								n_tg = TGT_NONE;
							end
							n_zr = '0;
							n_ph = PH_HDR;
						end else begin
							if (ph_q == PH_BODY) begin
								app_tg = tg_q;
							end
							if (data_byte == 8'h00) begin
								if (zr_q != 2'd3) begin
									n_zr = zr_q + 2'd1;
								end
							end else begin
								n_zr = '0;
							end
						end
					end
				endcase
				// append the byte to the set being captured
				case (app_tg)
					TGT_SEQ: begin
						if (sl_q < LW'(NAL_MAX)) begin
							seq_we = 1'b1;
							waddr  = sl_q[AW-1:0];
						end
						if (sl_q < LW'(LEN_CAP)) begin
							n_sl = sl_q + 1'b1;
						end
					end
					TGT_PIC: begin
						if (pl_q < LW'(NAL_MAX)) begin
							pic_we = 1'b1;
							waddr  = pl_q[AW-1:0];
						end
						if (pl_q < LW'(LEN_CAP)) begin
							n_pl = pl_q + 1'b1;
						end
					end
					default: ;
				endcase
			end
			if (last_of_frame) begin
				// the open unit runs to the frame end, trailing zeros kept
				if (!n_lk) begin
					case (n_tg)
						TGT_SEQ: begin
							cs   = close_len(n_sl, 2'd0);
							n_sl = cs.len;
							n_ov = n_ov | cs.ovf;
						end
						TGT_PIC: begin
							cs   = close_len(n_pl, 2'd0);
							n_pl = cs.len;
							n_ov = n_ov | cs.ovf;
						end
						default: ;
					endcase
					if (n_tg != TGT_NONE && n_sl != '0 && n_pl != '0) begin
						n_lk = 1'b1;
					end
					if (!n_lk) begin
						n_sl = '0;
						n_pl = '0;
					end
				end
				n_tg = TGT_NONE;
				n_zr = '0;
				n_ph = PH_HUNT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zr_q <= '0;
			ph_q <= PH_HUNT;
			ut_q <= '0;
			tg_q <= TGT_NONE;
			sl_q <= '0;
			pl_q <= '0;
			ov_q <= 1'b0;
			lk_q <= 1'b0;
		end else begin
			zr_q <= n_zr;
			ph_q <= n_ph;
			ut_q <= n_ut;
			tg_q <= n_tg;
			sl_q <= n_sl;
			pl_q <= n_pl;
			ov_q <= n_ov;
			lk_q <= n_lk;
		end
	end

	assign seq_len      = sl_q;
	assign pic_len      = pl_q;
	assign sts.nal_kind = ut_q;
	assign sts.in_body  = (ph_q == PH_BODY);
	assign sts.locked   = lk_q;
	assign sts.too_long = ov_q;

endmodule

// ===== rtl/h264psc_rec.sv =====
module h264psc_rec
	import h264psc_pkg::*;
#(
	parameter int NAL_MAX = 64,
	localparam int LW = $clog2(NAL_MAX + 5),
	localparam int AW = $clog2(NAL_MAX)
) (
	input  logic          clk,
	input  logic          en,
	input  logic          rd,
	input  logic [7:0]    read_index,
	input  logic          locked,
	input  logic [LW-1:0] seq_len,
	input  logic [LW-1:0] pic_len,
	output logic [AW-1:0] seq_raddr,
	output logic [AW-1:0] pic_raddr,
	input  logic [7:0]    seq_rdata,
	input  logic [7:0]    pic_rdata,
	output logic [7:0]    record_length,
	output logic [7:0]    record_byte
);

	localparam int IW = LW + 4;

	typedef enum logic [2:0] {
		SRC_CONST = 3'b001,
		SRC_SEQ   = 3'b010,
		SRC_PIC   = 3'b100
	} src_t;

	logic [IW-1:0] idx, s, p, total, seq_off, pic_off;
	logic [15:0]   s16, p16;
	logic          rec_ok;
	src_t          src, src_s2;
	logic [7:0]    cval, cval_s2;

	assign idx   = IW'(read_index);
	assign s     = IW'(seq_len);
	assign p     = IW'(pic_len);
	assign s16   = 16'(seq_len);
	assign p16   = 16'(pic_len);
	assign total = IW'(11) + s + p;

	assign rec_ok = locked && seq_len >= LW'(MIN_SET_LEN) && pic_len >= LW'(MIN_SET_LEN) &&
		seq_len <= LW'(NAL_MAX) && pic_len <= LW'(NAL_MAX);

	assign record_length = rec_ok ? total[7:0] : 8'd0;

	assign seq_off   = (idx <= IW'(3)) ? idx : idx - IW'(8);
	assign pic_off   = idx - IW'(11) - s;
	assign seq_raddr = seq_off[AW-1:0];
	assign pic_raddr = pic_off[AW-1:0];

	// scan words return a zero record byte
	always_comb begin
		src  = SRC_CONST;
		cval = 8'd0;
		if (rd && rec_ok && idx < total) begin
			if (idx == IW'(0)) begin
				cval = REC_VERSION;
			end else if (idx <= IW'(3)) begin
				src = SRC_SEQ;
			end else if (idx == IW'(4)) begin
				cval = REC_LEN_SIZE;
			end else if (idx == IW'(5)) begin
				cval = REC_NUM_SPS;
			end else if (idx == IW'(6)) begin
				cval = s16[15:8];
			end else if (idx == IW'(7)) begin
				cval = s16[7:0];
			end else if (idx < IW'(8) + s) begin
				src = SRC_SEQ;
			end else if (idx == IW'(8) + s) begin
				cval = REC_NUM_PPS;
			end else if (idx == IW'(9) + s) begin
				cval = p16[15:8];
			end else if (idx == IW'(10) + s) begin
				cval = p16[7:0];
			end else begin
				src = SRC_PIC;
			end
		end
	end

	// the store read lands together with this select
	always_ff @(posedge clk) begin
		if (en) begin
			src_s2  <= src;
			cval_s2 <= cval;
		end
	end

	always_comb begin
		case (src_s2)
			SRC_SEQ: record_byte = seq_rdata;
			SRC_PIC: record_byte = pic_rdata;
			default: record_byte = cval_s2;
		endcase
	end

endmodule

// ===== rtl/h264_parameter_set_capture_top.sv =====
// Captures the first sequence and picture parameter sets of a key frame from an
// Annex B byte stream and serves the AVC configuration record built from them, one
// byte per read command. One word is taken each clock unless in_stall holds it, and
// every word returns one result: an input register feeds the scan logic and the store
// read, and a result register holds the answer, so the input stalls while a stalled
// result waits. Both stores are single memories with one write and one registered
// read per cycle; they need no clearing after reset.
`include "h264_parameter_set_capture_top_defines.svh"

module h264_parameter_set_capture_top
	import h264psc_pkg::*;
#(
	parameter int NAL_MAX = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  cmd,
	input  logic [7:0]            data_byte,
	input  logic                  last_of_frame,
	input  logic                  key_frame,
	input  logic [7:0]            read_index,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [NAL_TYPE_W-1:0] nal_kind,
	output logic                  inside_unit,
	output logic                  params_ready,
	output logic [7:0]            record_length,
	output logic [7:0]            record_byte,
	output logic                  too_long
);

	localparam int LW = $clog2(NAL_MAX + 5);
	localparam int AW = $clog2(NAL_MAX);

	logic          valid_s1, valid_s2, adv;
	logic          cmd_s1, last_s1, key_s1;
	logic [7:0]    byte_s1, idx_s1;
	logic          seq_we, pic_we, scan_en, read_en;
	logic [AW-1:0] waddr, seq_raddr, pic_raddr;
	logic [7:0]    seq_rdata, pic_rdata;
	logic [LW-1:0] seq_len, pic_len;
	status_t       sts;

	// advance when the result register is free or being drained
	assign adv      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign scan_en  = adv && cmd_s1 == CMD_SCAN;
	assign read_en  = adv && cmd_s1 == CMD_READ;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1  <= cmd;
			byte_s1 <= data_byte;
			last_s1 <= last_of_frame;
			key_s1  <= key_frame;
			idx_s1  <= read_index;
		end
	end

	h264psc_scan #(.NAL_MAX(NAL_MAX)) u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (scan_en),
		.data_byte     (byte_s1),
		.last_of_frame (last_s1),
		.key_frame     (key_s1),
		.seq_we        (seq_we),
		.pic_we        (pic_we),
		.waddr         (waddr),
		.seq_len       (seq_len),
		.pic_len       (pic_len),
		.sts           (sts)
	);

	h264psc_ram #(.WIDTH(8), .DEPTH(NAL_MAX)) u_seq_ram (
		.clk   (clk),
		.we    (seq_we),
		.waddr (waddr),
		.wdata (byte_s1),
		.re    (read_en),
		.raddr (seq_raddr),
		.rdata (seq_rdata)
	);

	h264psc_ram #(.WIDTH(8), .DEPTH(NAL_MAX)) u_pic_ram (
		.clk   (clk),
		.we    (pic_we),
		.waddr (waddr),
		.wdata (byte_s1),
		.re    (read_en),
		.raddr (pic_raddr),
		.rdata (pic_rdata)
	);

	h264psc_rec #(.NAL_MAX(NAL_MAX)) u_rec (
		.clk           (clk),
		.en            (adv),
		.rd            (cmd_s1 == CMD_READ),
		.read_index    (idx_s1),
		.locked        (sts.locked),
		.seq_len       (seq_len),
		.pic_len       (pic_len),
		.seq_raddr     (seq_raddr),
		.pic_raddr     (pic_raddr),
		.seq_rdata     (seq_rdata),
		.pic_rdata     (pic_rdata),
		.record_length (record_length),
		.record_byte   (record_byte)
	);

	// scan state moves only when a word enters the result register
	assign out_valid    = valid_s2;
	assign nal_kind     = sts.nal_kind;
	assign inside_unit  = sts.in_body;
	assign params_ready = sts.locked;
	assign too_long     = sts.too_long;

	`H264PSC_ASSERT(a_lock_sticky, params_ready |=> params_ready, "lock released")
	`H264PSC_ASSERT(a_ovf_sticky, too_long |=> too_long, "overflow flag cleared")
	`H264PSC_ASSERT(a_lock_lengths, params_ready |-> (seq_len != '0 && pic_len != '0), "locked with empty set")
	`H264PSC_NEVER(a_len_unlocked, record_length != 8'd0 && !params_ready, "record length while unlocked")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import h264psc_pkg::*;

	localparam int NAL_MAX = 64;
	localparam int LEN_CAP = NAL_MAX + 4;
	localparam int RECORD_OVERHEAD = 11;
	localparam int RANDOM_FRAME_ITEMS = 1450;
	localparam int ITEM_TARGET = 2000;
	localparam int CYCLE_LIMIT = 200000;

	typedef enum {KEY_ALL, KEY_NONE, KEY_MIXED} key_style_t;
	typedef enum {ONLY_SEQ, ONLY_PIC, BOTH_NOT_KEY, ONE_TOO_LONG, FILLER_ONLY, NOISE_FRAME,
		LOCK_PAIR} frame_style_t;
	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_style_t;

	typedef struct packed {
		logic [NAL_TYPE_W-1:0] nal_kind;
		logic                  in_body;
		logic                  ready;
		logic [7:0]            rec_len;
		logic [7:0]            rec_byte;
		logic                  too_long;
	} status_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic cmd = CMD_SCAN;
	logic [7:0] data_byte = 8'h00;
	logic last_of_frame = 1'b0;
	logic key_frame = 1'b0;
	logic [7:0] read_index = 8'h00;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [NAL_TYPE_W-1:0] nal_kind;
	logic inside_unit;
	logic params_ready;
	logic [7:0] record_length;
	logic [7:0] record_byte;
	logic too_long;

	h264_parameter_set_capture_top #(.NAL_MAX(NAL_MAX)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.data_byte(data_byte),
		.last_of_frame(last_of_frame),
		.key_frame(key_frame),
		.read_index(read_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.nal_kind(nal_kind),
		.inside_unit(inside_unit),
		.params_ready(params_ready),
		.record_length(record_length),
		.record_byte(record_byte),
		.too_long(too_long)
	);

	always #10 clk = ~clk;

	// capture state mirrored from the block
	int unsigned zero_count = 0;
	phase_t parse_phase = PH_HUNT;
	logic [4:0] unit_kind = '0;
	target_t capture_into = TGT_NONE;
	logic [7:0] sps_mem [NAL_MAX];
	logic [7:0] pps_mem [NAL_MAX];
	int unsigned sps_len = 0;
	int unsigned pps_len = 0;
	bit overflow_seen = 0;
	bit sets_locked = 0;

	status_word_t predicted_status[$];
	logic [7:0] frame_bytes[$];
	logic [4:0] plan_kinds[$];
	int plan_lens[$];
	int errors = 0;
	int items_sent = 0;
	int burst_left = 0;
	int cycle_count = 0;
	stall_style_t stall_style = STALL_NONE;
	int stall_left = 0;

	function automatic void finish_capture(int unsigned dropped);
		target_t t;
		int unsigned n;
		t = capture_into;
		capture_into = TGT_NONE;
		if (t == TGT_SEQ)
			n = sps_len;
		else if (t == TGT_PIC)
			n = pps_len;
		else
			return;
		n = (n >= dropped) ? n - dropped : 0;
		if (n > NAL_MAX) begin
			overflow_seen = 1;
			n = 0;
		end
		if (t == TGT_SEQ)
			sps_len = n;
		else
			pps_len = n;
		if (sps_len != 0 && pps_len != 0)
			sets_locked = 1;
	endfunction

	function automatic void store_capture_byte(logic [7:0] b);
		if (capture_into == TGT_SEQ) begin
			if (sps_len < NAL_MAX)
				sps_mem[sps_len] = b;
			if (sps_len < LEN_CAP)
				sps_len++;
		end else if (capture_into == TGT_PIC) begin
			if (pps_len < NAL_MAX)
				pps_mem[pps_len] = b;
			if (pps_len < LEN_CAP)
				pps_len++;
		end
	endfunction

	function automatic void scan_stream_byte(logic [7:0] b);
		if (parse_phase == PH_HDR) begin
			unit_kind = b[4:0];
			capture_into = TGT_NONE;
			if (unit_kind == NAL_SPS && sps_len == 0)
				capture_into = TGT_SEQ;
			else if (unit_kind == NAL_PPS && pps_len == 0)
				capture_into = TGT_PIC;
			store_capture_byte(b);
			zero_count = 0;
			parse_phase = PH_BODY;
		end else if (b == START_BYTE && zero_count >= 2) begin
			if (parse_phase == PH_BODY)
				finish_capture(zero_count);
			zero_count = 0;
			parse_phase = PH_HDR;
		end else begin
			if (parse_phase == PH_BODY)
				store_capture_byte(b);
			if (b == 8'h00) begin
				if (zero_count < 3)
					zero_count++;
			end else begin
				zero_count = 0;
			end
		end
	endfunction

	function automatic void finish_frame();
		if (!sets_locked) begin
			finish_capture(0);
			if (!sets_locked) begin
				sps_len = 0;
				pps_len = 0;
			end
		end
		capture_into = TGT_NONE;
		zero_count = 0;
		parse_phase = PH_HUNT;
	endfunction

	function automatic bit record_ok();
		return sets_locked && sps_len >= MIN_SET_LEN && pps_len >= MIN_SET_LEN &&
			sps_len <= NAL_MAX && pps_len <= NAL_MAX;
	endfunction

	function automatic logic [7:0] config_record_byte(int unsigned i);
		int unsigned s;
		int unsigned p;
		s = sps_len;
		p = pps_len;
		if (!record_ok() || i >= RECORD_OVERHEAD + s + p)
			return 8'h00;
		if (i == 0)
			return REC_VERSION;
		if (i <= 3)
			return sps_mem[i];
		if (i == 4)
			return REC_LEN_SIZE;
		if (i == 5)
			return REC_NUM_SPS;
		if (i == 6)
			return 8'(s >> 8);
		if (i == 7)
			return 8'(s);
		if (i < 8 + s)
			return sps_mem[i - 8];
		if (i == 8 + s)
			return REC_NUM_PPS;
		if (i == 9 + s)
			return 8'(p >> 8);
		if (i == 10 + s)
			return 8'(p);
		return pps_mem[i - RECORD_OVERHEAD - s];
	endfunction

	function automatic status_word_t next_status(logic c, logic [7:0] b, logic last, logic key,
		logic [7:0] idx);
		status_word_t r;
		r.rec_byte = 8'h00;
		if (c == CMD_SCAN) begin
			if (!sets_locked) begin
				if (key)
					scan_stream_byte(b);
				if (last)
					finish_frame();
			end
		end else begin
			r.rec_byte = config_record_byte(idx);
		end
		r.nal_kind = unit_kind;
		r.in_body = (parse_phase == PH_BODY);
		r.ready = sets_locked;
		r.rec_len = record_ok() ? 8'(RECORD_OVERHEAD + sps_len + pps_len) : 8'h00;
		r.too_long = overflow_seen;
		return r;
	endfunction

	task automatic compare_field(string what, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			if (errors < 40)
				$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : check_results
		status_word_t want;
		if (arst_n) begin
			// predict before retiring so a word is queued ahead of its result
			if (in_valid && !in_stall)
				predicted_status.insert(predicted_status.size(), next_status(cmd, data_byte,
					last_of_frame, key_frame, read_index));
			if (out_valid && !out_stall) begin
				if (predicted_status.size() == 0) begin
					if (errors < 40)
						$display("%0t: result word with nothing expected, nal_kind %0d",
							$time, nal_kind);
					errors++;
				end else begin
					want = predicted_status.pop_front();
					compare_field("nal_kind", 8'(want.nal_kind), 8'(nal_kind));
					compare_field("inside_unit", 8'(want.in_body), 8'(inside_unit));
					compare_field("params_ready", 8'(want.ready), 8'(params_ready));
					compare_field("record_length", want.rec_len, record_length);
					compare_field("record_byte", want.rec_byte, record_byte);
					compare_field("too_long", 8'(want.too_long), 8'(too_long));
				end
			end
		end
	end

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_style = stall_style_t'($urandom_range(0, 3));
			stall_left = $urandom_range(8, 80);
		end
		stall_left--;
		case (stall_style)
		STALL_NONE: out_stall <= 1'b0;
		STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
		STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
		default: out_stall <= ~out_stall;
		endcase
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_word(logic c, logic [7:0] b, logic last, logic key, logic [7:0] idx);
		@(negedge clk);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) :
				$urandom_range(1, 12);
		end
		in_valid <= 1'b1;
		cmd <= c;
		data_byte <= b;
		last_of_frame <= last;
		key_frame <= key;
		read_index <= idx;
		burst_left--;
		items_sent++;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_record_read(logic [7:0] idx);
		send_word(CMD_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), idx);
	endtask

	task automatic wait_results_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (predicted_status.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_frame(key_style_t ks);
		logic key;
		for (int i = 0; i < frame_bytes.size(); i++) begin
			if ($urandom_range(0, 24) == 0)
				send_record_read(8'($urandom_range(0, 255)));
			case (ks)
			KEY_ALL: key = 1'b1;
			KEY_NONE: key = 1'b0;
			default: key = 1'($urandom_range(0, 1));
			endcase
			send_word(CMD_SCAN, frame_bytes[i], i == frame_bytes.size() - 1, key,
				8'($urandom_range(0, 255)));
		end
	endtask

	task automatic add_start_code(int zeros);
		repeat (zeros) frame_bytes.insert(frame_bytes.size(), 8'h00);
		frame_bytes.insert(frame_bytes.size(), START_BYTE);
	endtask

	task automatic add_unit(logic [4:0] kind, int len, bit clean_tail);
		logic [7:0] b;
		int n;
		frame_bytes.insert(frame_bytes.size(), {3'($urandom_range(0, 7)), kind});
		for (int i = 1; i < len; i++) begin
			b = ($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
			if (clean_tail && i == len - 1 && b == 8'h00)
				b = 8'h80;
			n = frame_bytes.size();
			// insert an emulation prevention byte instead of a stray start code
			if (n >= 2 && b == START_BYTE && frame_bytes[n-1] == 8'h00 &&
				frame_bytes[n-2] == 8'h00)
				b = 8'h03;
			frame_bytes.insert(frame_bytes.size(), b);
		end
	endtask

	function automatic logic [4:0] filler_kind();
		int k;
		k = $urandom_range(0, 29);
		if (k >= NAL_SPS)
			k += 2;
		return 5'(k);
	endfunction

	function automatic int unit_len();
		return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 70) : $urandom_range(1, 16);
	endfunction

	task automatic place_unit(logic [4:0] kind, int len);
		int pos;
		pos = $urandom_range(0, plan_kinds.size());
		plan_kinds.insert(pos, kind);
		plan_lens.insert(pos, len);
	endtask

	task automatic build_frame(frame_style_t st, output key_style_t ks);
		logic [7:0] b;
		bit set_unit;
		frame_bytes.delete();
		plan_kinds.delete();
		plan_lens.delete();
		ks = (st == BOTH_NOT_KEY) ? KEY_NONE : KEY_ALL;
		if (st == NOISE_FRAME) begin
			ks = KEY_MIXED;
			repeat ($urandom_range(4, 40)) begin
				case ($urandom_range(0, 4))
				0, 1: b = 8'h00;
				2: b = START_BYTE;
				default: b = 8'($urandom_range(0, 255));
				endcase
				// keep noise from ever naming a parameter set
				if (b[4:0] == NAL_SPS || b[4:0] == NAL_PPS)
					b[4] = ~b[4];
				frame_bytes.insert(frame_bytes.size(), b);
			end
			return;
		end
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3))
				frame_bytes.insert(frame_bytes.size(), 8'($urandom_range(0, 255)));
		repeat ($urandom_range(0, 3)) begin
			plan_kinds.insert(plan_kinds.size(), filler_kind());
			plan_lens.insert(plan_lens.size(), unit_len());
		end
		case (st)
		ONLY_SEQ: begin
			place_unit(NAL_SPS, unit_len());
			if ($urandom_range(0, 3) == 0)
				place_unit(NAL_SPS, unit_len());
		end
		ONLY_PIC: begin
			place_unit(NAL_PPS, unit_len());
			if ($urandom_range(0, 3) == 0)
				place_unit(NAL_PPS, unit_len());
		end
		BOTH_NOT_KEY: begin
			place_unit(NAL_SPS, unit_len());
			place_unit(NAL_PPS, unit_len());
		end
		ONE_TOO_LONG: begin
			// at least LEN_CAP bytes, so dropping trailing zeros cannot save it
			if ($urandom_range(0, 1)) begin
				place_unit(NAL_SPS, $urandom_range(LEN_CAP, LEN_CAP + 12));
				place_unit(NAL_PPS, unit_len());
			end else begin
				place_unit(NAL_SPS, unit_len());
				place_unit(NAL_PPS, $urandom_range(LEN_CAP, LEN_CAP + 12));
			end
		end
		LOCK_PAIR: begin
			place_unit(NAL_SPS, ($urandom_range(0, 2) == 0) ? NAL_MAX :
				$urandom_range(MIN_SET_LEN, NAL_MAX));
			place_unit(NAL_PPS, ($urandom_range(0, 2) == 0) ? NAL_MAX :
				$urandom_range(MIN_SET_LEN, NAL_MAX));
		end
		default: begin
			if (plan_kinds.size() == 0)
				place_unit(filler_kind(), unit_len());
		end
		endcase
		for (int i = 0; i < plan_kinds.size(); i++) begin
			set_unit = plan_kinds[i] == NAL_SPS || plan_kinds[i] == NAL_PPS;
			add_start_code(($urandom_range(0, 3) == 0) ? $urandom_range(3, 6) : 2);
			add_unit(plan_kinds[i], plan_lens[i], st == LOCK_PAIR && set_unit);
		end
		case ($urandom_range(0, 7))
		0: repeat ($urandom_range(1, 4)) frame_bytes.insert(frame_bytes.size(), 8'h00);
		1: add_start_code(2);
		2: begin
			add_start_code(3);
			frame_bytes.insert(frame_bytes.size(), {3'($urandom_range(0, 7)), filler_kind()});
		end
		default: ;
		endcase
	endtask

	task automatic test_reads_before_lock();
		send_word(CMD_READ, 8'h00, 1'b0, 1'b0, 8'd0);
		send_word(CMD_READ, 8'hff, 1'b1, 1'b1, 8'd255);
		send_word(CMD_READ, 8'h5a, 1'b0, 1'b1, 8'd138);
	endtask

	task automatic test_start_code_forms();
		// four-byte start code, surplus zeros kept in the unit, frame ends on a start code
		frame_bytes = '{8'h00, 8'h00, 8'h00, START_BYTE, 8'he7, 8'h42, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, START_BYTE, 8'h06, 8'hff, 8'h00, 8'h00, START_BYTE};
		send_frame(KEY_ALL);
		// both sets in a non-key frame are never scanned
		frame_bytes = '{8'h00, 8'h00, START_BYTE, 8'h67, 8'h11, 8'h00, 8'h00, START_BYTE,
			8'h68, 8'h22};
		send_frame(KEY_NONE);
	endtask

	task automatic test_oversized_sets();
		frame_bytes.delete();
		add_start_code(3);
		add_unit(NAL_SPS, NAL_MAX, 1);
		add_start_code(2);
		add_unit(filler_kind(), 3, 0);
		send_frame(KEY_ALL);
		frame_bytes.delete();
		add_start_code(2);
		add_unit(NAL_PPS, NAL_MAX + 1, 1);
		send_frame(KEY_ALL);
		// a dropped set frees its slot for a later unit of the same type
		frame_bytes.delete();
		add_start_code(2);
		add_unit(NAL_SPS, LEN_CAP + 2, 1);
		add_start_code(2);
		add_unit(NAL_SPS, 10, 0);
		send_frame(KEY_ALL);
	endtask

	task automatic test_random_frames();
		frame_style_t st;
		key_style_t ks;
		bit paused;
		paused = 0;
		while (items_sent < RANDOM_FRAME_ITEMS) begin
			st = frame_style_t'($urandom_range(0, 5));
			build_frame(st, ks);
			send_frame(ks);
			if (!paused && items_sent > RANDOM_FRAME_ITEMS / 2) begin
				wait_results_drained();
				paused = 1;
			end
		end
	endtask

	task automatic test_lock_and_read();
		key_style_t ks;
		int tries;
		int rec_len;
		int reads_left;
		int pick;
		tries = 0;
		wait_results_drained();
		while (!sets_locked && tries < 20) begin
			build_frame(LOCK_PAIR, ks);
			send_frame(ks);
			wait_results_drained();
			tries++;
		end
		rec_len = record_ok() ? RECORD_OVERHEAD + sps_len + pps_len : 0;
		for (int i = 0; i < 8; i++)
			send_record_read(8'(i));
		send_record_read(8'(rec_len - 1));
		send_record_read(8'(rec_len));
		send_record_read(8'd255);
		reads_left = ITEM_TARGET - items_sent;
		while (reads_left > 0) begin
			pick = $urandom_range(0, 9);
			if (pick < 6 && rec_len > 0) begin
				send_record_read(8'($urandom_range(0, rec_len - 1)));
				reads_left--;
			end else if (pick < 9) begin
				send_record_read(8'($urandom_range(0, 255)));
				reads_left--;
			end else begin
				// scan words after the lock change nothing
				send_word(CMD_SCAN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reads_before_lock();
		test_start_code_forms();
		test_oversized_sets();
		test_random_frames();
		test_lock_and_read();
		wait_results_drained();
		repeat (20) @(posedge clk);
		if (errors == 0 && predicted_status.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
